>>> hw/rtl/murmur3_32_byte_stream_hash_core_macros.svh
// Assertion macros for the murmur3 byte stream hash core.
`ifndef MURMUR3_32_BYTE_STREAM_HASH_CORE_MACROS_SVH
`define MURMUR3_32_BYTE_STREAM_HASH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define M3H_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define M3H_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define M3H_ASSERT_IMP(label, ante, cons)
`define M3H_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/m3h_pkg.sv
`default_nettype none
package m3h_pkg;

  localparam logic [31:0] MIX_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2   = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD = 32'he6546b64;
  localparam logic [31:0] FIN_M1   = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2   = 32'hc2b2ae35;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one queued command: an optional full block, then optionally the key end
  typedef struct packed {
    logic        do_block;
    logic        do_final;
    logic        first;
    logic [31:0] seed;
    logic [31:0] block;
    logic [23:0] tail;
    logic [31:0] len;
  } m3h_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BMIX1,
    S_BMIX2,
    S_FOLD,
    S_TMIX1,
    S_TMIX2,
    S_FIN1,
    S_FIN2,
    S_FIN3
  } m3h_state_t;

  function automatic logic [31:0] rotl15(input logic [31:0] v);
    return {v[16:0], v[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] v);
    return {v[18:0], v[31:19]};
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/murmur3_32_byte_stream_hash_core.sv
// MurmurHash3 x86_32 of a key streamed one byte per item.
// Input channel (in_valid/in_ready): key_byte, byte_valid, last. Bytes come
// in key order; the item with last set closes the key. byte_valid 0 with
// last 1 closes the key without a byte (alone it is the empty key);
// byte_valid 0 with last 0 is taken and has no effect.
// Output channel (out_valid/out_ready): hash_value, one item per key.
// cfg_we/cfg_data write the seed; a key picks up the seed current when it
// begins.
// The front packs bytes into 32-bit blocks and hands block and key-end
// commands through a two-entry queue to the back, which runs them on one
// shared 32x32 multiplier: a block in two mix steps and a fold, a key end in
// two tail mix steps and three finalisation steps; it takes a new command
// only when idle. Bytes within a key stream at one per cycle while the queue
// has room; out_valid rises once the key end's steps and any ahead have run.
// in_ready drops only while the queue is full.
// A result held by a stalled receiver stops the back in its last step; the
// front keeps taking items until the queue fills.
// Reset clears the seed to zero, drops any partial key and any held result.
`default_nettype none
module murmur3_32_byte_stream_hash_core
  import m3h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  key_byte,
  input  wire logic        byte_valid,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      hash_value
);

  logic     q_full;
  logic     q_avail;
  logic     push;
  logic     pop;
  m3h_cmd_t push_cmd;
  m3h_cmd_t pop_cmd;

  m3h_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_byte   (key_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  m3h_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .avail    (q_avail),
    .pop      (pop),
    .pop_cmd  (pop_cmd)
  );

  m3h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (q_avail),
    .cmd_in     (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule
`default_nettype wire

>>> hw/rtl/m3h_front.sv
`default_nettype none
module m3h_front
  import m3h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  key_byte,
  input  wire logic        byte_valid,
  input  wire logic        last,
  input  wire logic        q_full,
  output logic             push,
  output m3h_cmd_t         push_cmd
);

  logic [31:0] seed;
  logic [31:0] key_seed;
  logic        key_active;
  logic        sent;
  logic [23:0] partial;
  logic [1:0]  pos;
  logic [31:0] len;

  logic        accept;
  logic        blk_done;
  logic [23:0] partial_next;
  logic [1:0]  pos_next;
  logic [31:0] len_next;
  logic [31:0] cur_seed;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign blk_done = byte_valid && (pos == 2'd3);
  assign cur_seed = key_active ? key_seed : seed;
  assign len_next = len + {31'b0, byte_valid};

  always_comb begin
    partial_next = partial;
    pos_next     = pos;
    if (byte_valid) begin
      pos_next = pos + 2'd1;
      case (pos)
        2'd0: partial_next = {partial[23:8], key_byte};
        2'd1: partial_next = {partial[23:16], key_byte, partial[7:0]};
        2'd2: partial_next = {key_byte, partial[15:0]};
        default: partial_next = '0;
      endcase
    end
  end

  assign push = accept && (blk_done || last);

  always_comb begin
    push_cmd.do_block = blk_done;
    push_cmd.do_final = last;
    push_cmd.first    = !sent;
    push_cmd.seed     = cur_seed;
    push_cmd.block    = {key_byte, partial};
    push_cmd.tail     = partial_next;
    push_cmd.len      = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      key_seed   <= '0;
      key_active <= 1'b0;
      sent       <= 1'b0;
      partial    <= '0;
      pos        <= '0;
      len        <= '0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_data;
      end
      if (accept) begin
        if (last) begin
          key_active <= 1'b0;
          sent       <= 1'b0;
          partial    <= '0;
          pos        <= '0;
          len        <= '0;
        end else if (byte_valid) begin
          if (!key_active) begin
            key_seed <= seed;
          end
          key_active <= 1'b1;
          if (push) begin
            sent <= 1'b1;
          end
          partial <= partial_next;
          pos     <= pos_next;
          len     <= len_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/m3h_queue.sv
`default_nettype none
`include "murmur3_32_byte_stream_hash_core_macros.svh"
module m3h_queue
  import m3h_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire m3h_cmd_t  push_cmd,
  output logic           full,
  output logic           avail,
  input  wire logic      pop,
  output m3h_cmd_t       pop_cmd
);

  m3h_cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic [QCNT_W-1:0]     count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign avail   = (count != '0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `M3H_ASSERT_IMP(q_no_overflow, push && !pop, count < QCNT_W'(QDEPTH))
  `M3H_ASSERT_IMP(q_no_underflow, pop, count != '0)
  `M3H_ASSERT_NEXT(q_pop_dec, pop && !push, count == $past(count) - 1'b1)

endmodule
`default_nettype wire

>>> hw/rtl/m3h_back.sv
`default_nettype none
`include "murmur3_32_byte_stream_hash_core_macros.svh"
module m3h_back
  import m3h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        avail,
  input  wire m3h_cmd_t    cmd_in,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      hash_value
);

  m3h_state_t  state;
  m3h_state_t  state_next;
  m3h_cmd_t    cmd;
  logic [31:0] h;
  logic [31:0] prod;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_full;
  logic        prod_en;
  logic        out_load;
  logic [31:0] fold_r;
  logic [31:0] fin_x;

  assign mul_full = mul_a * mul_b;
  assign fold_r   = rotl13(h ^ prod);
  assign fin_x    = h ^ prod ^ cmd.len;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (avail) state_next = cmd_in.do_block ? S_BMIX1 : S_TMIX1;
      S_BMIX1: state_next = S_BMIX2;
      S_BMIX2: state_next = S_FOLD;
      S_FOLD:  state_next = cmd.do_final ? S_TMIX1 : S_IDLE;
      S_TMIX1: state_next = S_TMIX2;
      S_TMIX2: state_next = S_FIN1;
      S_FIN1:  state_next = S_FIN2;
      S_FIN2:  state_next = S_FIN3;
      S_FIN3:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    prod_en  = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_IDLE:  pop = avail;
      S_BMIX1: begin
        prod_en = 1'b1;
        mul_a   = cmd.block;
        mul_b   = MIX_C1;
      end
      S_BMIX2: begin
        prod_en = 1'b1;
        mul_a   = rotl15(prod);
        mul_b   = MIX_C2;
      end
      S_TMIX1: begin
        prod_en = 1'b1;
        mul_a   = {8'b0, cmd.tail};
        mul_b   = MIX_C1;
      end
      S_TMIX2: begin
        prod_en = 1'b1;
        mul_a   = rotl15(prod);
        mul_b   = MIX_C2;
      end
      S_FIN1: begin
        prod_en = 1'b1;
        mul_a   = fin_x ^ {16'b0, fin_x[31:16]};
        mul_b   = FIN_M1;
      end
      S_FIN2: begin
        prod_en = 1'b1;
        mul_a   = prod ^ {13'b0, prod[31:13]};
        mul_b   = FIN_M2;
      end
      S_FIN3:  out_load = !out_valid || out_ready;
      default: pop = 1'b0;
    endcase
  end

  // an empty tail mixes to zero, so the tail path runs unconditionally
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= cmd_in;
      if (cmd_in.first) begin
        h <= cmd_in.seed;
      end
    end
    if (prod_en) begin
      prod <= mul_full;
    end
    if (state == S_FOLD) begin
      h <= {fold_r[29:0], 2'b00} + fold_r + FOLD_ADD;
    end
    if (out_load) begin
      hash_value <= prod ^ {16'b0, prod[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `M3H_ASSERT_NEXT(bk_start, state == S_IDLE && avail, state != S_IDLE)
  `M3H_ASSERT_IMP(bk_pop_idle, pop, state == S_IDLE)

endmodule
`default_nettype wire
